>>> hw/rtl/gwm_pkg.sv
package gwm_pkg;

  // Command carried by every input item.
  typedef enum logic {
    CmdFilter = 1'b0,
    CmdName   = 1'b1
  } cmd_e;

  // Character codes that the matcher treats specially.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

endpackage

>>> hw/rtl/gwm_if.sv
interface gwm_item_if;
  import gwm_pkg::*;

  logic       valid;
  logic       ready;
  cmd_e       cmd;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output cmd, output ch, output last, input ready);
  modport sink   (input valid, input cmd, input ch, input last, output ready);
endinterface

interface gwm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink   (input valid, input matched, input overflow, output ready);
endinterface

>>> hw/rtl/generic_name_wildcard_match.sv
// Wildcard matcher for generic type names. Items with cmd = filter load a
// pattern one character at a time (last closes it; the next filter item
// starts a new pattern), and items with cmd = name stream a type name, one
// character per item; the name item with last set yields one result item
// carrying matched and overflow, and no other item yields a result. Spaces
// and zero bytes are ignored in both strings. A '*' in the pattern skips one
// generic argument, and a ',' or '>' directly after '<' or ',' in the pattern
// also matches any argument. Up to MAX_FILTER pattern characters are kept,
// and argument nesting inside a skip is tracked to MAX_NESTING levels; going
// past either sets overflow and the result should not be trusted. The block
// takes one item per clock while the result register is free or being
// drained: an item enters an input register, is processed once the pipeline
// advances, against the pattern character that the filter store's
// registered read port already holds, and a name end lands in the result
// register. While one result waits, the input register can still take one
// more item, after which the input is held off. The pattern store needs no
// clearing after reset.
module generic_name_wildcard_match #(
  parameter int MAX_FILTER  = 64,
  parameter int MAX_NESTING = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gwm_item_if.sink     item_i,
  gwm_result_if.source result_o
);
  import gwm_pkg::*;

  logic    advance;
  logic    in_fire;
  logic    go;
  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    res_valid_q, res_valid_d;
  result_t res_q;
  result_t core_res;

  // The pipeline moves whenever the result register is free or being drained.
  assign advance      = !res_valid_q || result_o.ready;
  assign item_i.ready = advance || !s1_valid_q;
  assign in_fire      = item_i.valid && item_i.ready;
  assign go           = advance && s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = go && (s1_item_q.cmd == CmdName) && s1_item_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.cmd  <= item_i.cmd;
      s1_item_q.ch   <= item_i.ch;
      s1_item_q.last <= item_i.last;
    end
    if (advance) begin
      res_q <= core_res;
    end
  end

  gwm_match_core #(
    .MAX_FILTER  (MAX_FILTER),
    .MAX_NESTING (MAX_NESTING)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .item_i   (s1_item_q),
    .result_o (core_res)
  );

  assign result_o.valid    = res_valid_q;
  assign result_o.matched  = res_q.matched;
  assign result_o.overflow = res_q.overflow;

endmodule

>>> hw/rtl/gwm_filter_store.sv
module gwm_filter_store #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Registered read; a write to the address being read is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gwm_match_core.sv
module gwm_match_core #(
  parameter int MAX_FILTER  = 64,
  parameter int MAX_NESTING = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  gwm_pkg::item_t  item_i,
  output gwm_pkg::result_t result_o
);
  import gwm_pkg::*;

  localparam int LenW  = $clog2(MAX_FILTER + 1);
  localparam int AddrW = $clog2(MAX_FILTER);
  localparam int NestW = $clog2(MAX_NESTING + 1);
  localparam logic [LenW-1:0]  FilterMax = LenW'(MAX_FILTER);
  localparam logic [NestW-1:0] NestMax   = NestW'(MAX_NESTING);

  logic [LenW-1:0]  len_q, len_d, len_base;
  logic             complete_q, complete_d;
  logic             too_long_q, too_long_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [7:0]       prev_q, prev_d;
  logic             skip_q, skip_d;
  logic [NestW-1:0] nest_q, nest_d;
  logic             match_q, match_d;
  logic             ovf_q, ovf_d;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       fch;
  logic             usable;
  logic             do_cmp;
  logic             fin_match;

  // The read address follows the next filter position, so the character at
  // the current position is always waiting in the read register.
  gwm_filter_store #(
    .DEPTH (MAX_FILTER)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.ch),
    .raddr_i (pos_d[AddrW-1:0]),
    .rdata_o (fch)
  );

  assign usable = (item_i.ch != CharNul) && (item_i.ch != CharSpace);

  always_comb begin
    len_d      = len_q;
    complete_d = complete_q;
    too_long_d = too_long_q;
    pos_d      = pos_q;
    prev_d     = prev_q;
    skip_d     = skip_q;
    nest_d     = nest_q;
    match_d    = match_q;
    ovf_d      = ovf_q;
    len_base   = len_q;
    we         = 1'b0;
    waddr      = len_q[AddrW-1:0];
    do_cmp     = 1'b0;
    fin_match  = 1'b0;
    result_o   = '0;

    if (go_i) begin
      if (item_i.cmd == CmdFilter) begin
        // A filter item after a finished filter starts a new one.
        len_base   = complete_q ? '0 : len_q;
        too_long_d = complete_q ? 1'b0 : too_long_q;
        len_d      = len_base;
        if (usable) begin
          if (len_base < FilterMax) begin
            we    = 1'b1;
            waddr = len_base[AddrW-1:0];
            len_d = len_base + 1'b1;
          end else begin
            too_long_d = 1'b1;
          end
        end
        complete_d = item_i.last;
        pos_d      = '0;
        prev_d     = CharNul;
        skip_d     = 1'b0;
        nest_d     = '0;
        match_d    = 1'b1;
        ovf_d      = 1'b0;
      end else begin
        if (usable && match_q) begin
          if (skip_q) begin
            if ((item_i.ch == CharGt || item_i.ch == CharComma) && nest_q == '0) begin
              // The delimiter ends the skip and is compared again.
              skip_d = 1'b0;
              do_cmp = 1'b1;
            end else if (item_i.ch == CharLt) begin
              if (nest_q >= NestMax) begin
                ovf_d = 1'b1;
              end else begin
                nest_d = nest_q + 1'b1;
              end
            end else if (item_i.ch == CharGt) begin
              nest_d = nest_q - 1'b1;
            end
          end else begin
            do_cmp = 1'b1;
          end
        end

        if (do_cmp) begin
          if (pos_q >= len_q) begin
            match_d = 1'b0;
          end else if (item_i.ch == fch) begin
            pos_d  = pos_q + 1'b1;
            prev_d = fch;
          end else if (fch == CharStar) begin
            skip_d = 1'b1;
            nest_d = '0;
            pos_d  = pos_q + 1'b1;
            prev_d = fch;
          end else if ((fch == CharComma || fch == CharGt) &&
                       (prev_q == CharLt || prev_q == CharComma)) begin
            // Empty-argument wildcard: skip, but keep the filter position.
            skip_d = 1'b1;
            nest_d = '0;
            prev_d = fch;
          end else begin
            match_d = 1'b0;
          end
        end

        if (item_i.last) begin
          // An argument still open at the end of the name fails the match.
          fin_match         = match_d && !(skip_d && nest_d != '0);
          result_o.matched  = fin_match && (pos_d >= len_q);
          result_o.overflow = too_long_q || ovf_d;
          pos_d   = '0;
          prev_d  = CharNul;
          skip_d  = 1'b0;
          nest_d  = '0;
          match_d = 1'b1;
          ovf_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      complete_q <= 1'b0;
      too_long_q <= 1'b0;
      pos_q      <= '0;
      prev_q     <= CharNul;
      skip_q     <= 1'b0;
      nest_q     <= '0;
      match_q    <= 1'b1;
      ovf_q      <= 1'b0;
    end else begin
      len_q      <= len_d;
      complete_q <= complete_d;
      too_long_q <= too_long_d;
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      skip_q     <= skip_d;
      nest_q     <= nest_d;
      match_q    <= match_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

>>> hw/rtl/gwm_checker.sv
module gwm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_cmd_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_matched_i,
  input logic out_overflow_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_matched_i) && $stable(out_overflow_i))
    else $error("result changed or dropped while stalled");

  // With no result pending the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output register is empty");

  // A name end taken while the output is empty must produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_cmd_i && in_last_i && !out_valid_i |=> ##1 out_valid_i)
    else $error("name end produced no result");

  // With nothing in flight, no result appears from nowhere.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && $past(!out_valid_i) && !$past(in_fire) |=> !out_valid_i)
    else $error("result appeared without an item in flight");

endmodule

bind generic_name_wildcard_match gwm_checker u_gwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .in_cmd_i       (item_i.cmd),
  .in_last_i      (item_i.last),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_matched_i  (result_o.matched),
  .out_overflow_i (result_o.overflow)
);

>>> verif/tb_generic_name_wildcard_match.sv
`timescale 1ns / 1ps

module tb_generic_name_wildcard_match;
  import gwm_pkg::*;

  // Sizes the block is built with; the predictor uses the same bounds.
  localparam int PatDepth   = 64;
  localparam int NestMax    = 15;
  // Slack after the last expected result covers any item still in flight.
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 100000;
  localparam int ItemTarget  = 420;
  localparam int MinResults  = 30;

  logic clk;
  logic rst_n;

  gwm_item_if   item_if ();
  gwm_result_if res_if ();

  generic_name_wildcard_match #(
    .MAX_FILTER (PatDepth),
    .MAX_NESTING(NestMax)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  // Free-running clock, 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shared controls and counters.
  // ---------------------------------------------------------------------
  bit idle_on;         // sender inserts random gaps
  bit stall_on;        // receiver inserts random stalls
  bit mess_on;         // names and patterns get stray spaces and NUL ends
  int hold_req;        // request for one long receiver stall, in cycles
  int n_items;
  int n_results;
  int n_hits;
  int n_ovf;
  int n_mismatch;
  int cycles;

  // Expected result items, oldest first.
  result_t pending_results[$];

  // ---------------------------------------------------------------------
  // Matcher prediction. This is the testbench's own copy of the pattern
  // store and of the per-name match state.
  // ---------------------------------------------------------------------
  logic [7:0] pat_mem[PatDepth];
  int         pat_len;
  bit         pat_closed;     // last pattern item seen; next one starts anew
  bit         pat_dropped;    // a pattern character did not fit
  int         pat_pos;        // next pattern character to compare
  logic [7:0] prev_pat_ch;
  bit         in_skip;        // inside a skipped generic argument
  int         depth;          // nesting depth inside the skipped argument
  bit         alive;          // name still matches so far
  bit         deep_seen;      // nesting went past the bound in this name

  function automatic void restart_name();
    pat_pos     = 0;
    prev_pat_ch = CharNul;
    in_skip     = 1'b0;
    depth       = 0;
    alive       = 1'b1;
    deep_seen   = 1'b0;
  endfunction

  // Compare one name character with the pattern character at pat_pos.
  function automatic void compare_name_char(logic [7:0] c);
    logic [7:0] f;
    if (pat_pos >= pat_len) begin
      alive = 1'b0;
      return;
    end
    f = pat_mem[pat_pos];
    if (c == f) begin
      pat_pos++;
      prev_pat_ch = f;
    end else if (f == CharStar) begin
      // A star swallows one argument; the character that opened the skip
      // does not count toward the depth.
      in_skip     = 1'b1;
      depth       = 0;
      pat_pos++;
      prev_pat_ch = f;
    end else if ((f == CharComma || f == CharGt) &&
                 (prev_pat_ch == CharLt || prev_pat_ch == CharComma)) begin
      // An empty argument slot in the pattern also matches any argument,
      // but the delimiter stays put so that it is compared afterwards.
      in_skip     = 1'b1;
      depth       = 0;
      prev_pat_ch = f;
    end else begin
      alive = 1'b0;
    end
  endfunction

  function automatic void take_name_char(logic [7:0] c);
    if (!alive) return;
    if (in_skip) begin
      if ((c == CharGt || c == CharComma) && depth == 0) begin
        // The delimiter closes the skip and is then compared as usual.
        in_skip = 1'b0;
      end else begin
        if (c == CharLt) begin
          if (depth >= NestMax) deep_seen = 1'b1;
          else depth++;
        end else if (c == CharGt) begin
          depth--;
        end
        return;
      end
    end
    compare_name_char(c);
  endfunction

  // Advance the prediction by one accepted item; a name end queues the
  // expected result item.
  function automatic void predict_item(cmd_e c, logic [7:0] b, logic l);
    result_t want;
    bit usable;
    usable = (b != CharNul) && (b != CharSpace);
    if (c == CmdFilter) begin
      if (pat_closed) begin
        pat_len     = 0;
        pat_dropped = 1'b0;
        pat_closed  = 1'b0;
      end
      if (usable) begin
        if (pat_len < PatDepth) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end else begin
          pat_dropped = 1'b1;
        end
      end
      if (l) pat_closed = 1'b1;
      // A pattern item also abandons any name in progress.
      restart_name();
      return;
    end
    if (usable) take_name_char(b);
    if (!l) return;
    // An argument skip still open at the name end only passes when it sits
    // at depth zero; an unclosed '<' fails the name.
    if (alive && in_skip) begin
      if (depth != 0) alive = 1'b0;
      else in_skip = 1'b0;
    end
    want.matched  = alive && (pat_pos >= pat_len);
    want.overflow = pat_dropped || deep_seen;
    pending_results.push_back(want);
    restart_name();
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. The payload is driven with nonblocking assignments right
  // after a rising edge, and ready is sampled at the next edge, which gives
  // the pre-edge value. After an accepted item valid stays high so that a
  // back-to-back item needs no second assignment in the same time step;
  // every task that stops sending lowers it first.
  // ---------------------------------------------------------------------
  task automatic send_item(input cmd_e c, input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.cmd   <= c;
    item_if.ch    <= b;
    item_if.last  <= l;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    predict_item(c, b, l);
    n_items++;
  endtask

  // Send a whole pattern or name; an empty string becomes a lone NUL item
  // with last set. With mess_on, stray spaces and a trailing NUL end are
  // mixed in.
  task automatic send_string(input cmd_e c, input string s);
    bit nul_end;
    nul_end = mess_on && ($urandom_range(0, 5) == 0);
    if (s.len() == 0) begin
      send_item(c, CharNul, 1'b1);
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      if (mess_on && $urandom_range(0, 9) == 0) send_item(c, CharSpace, 1'b0);
      send_item(c, s.getc(i), (i == s.len() - 1) && !nul_end);
    end
    if (nul_end) send_item(c, CharNul, 1'b1);
  endtask

  // Stop sending until every expected result item has come back, then give
  // the pipeline a few more cycles in case a result-less item is in flight.
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stall bursts, plus one long stall on request.
  // Each pass of the loop makes one assignment to ready and then waits on
  // the clock.
  // ---------------------------------------------------------------------
  initial begin
    int n;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result item is compared with the oldest
  // expectation. A result with nothing expected is a failure as well.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: result item with none expected: matched=%b overflow=%b",
                   res_if.matched, res_if.overflow);
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (want.matched) n_hits++;
        if (want.overflow) n_ovf++;
        if (res_if.matched !== want.matched || res_if.overflow !== want.overflow) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d: expected matched=%b overflow=%b, got matched=%b overflow=%b",
                     n_results, want.matched, want.overflow,
                     res_if.matched, res_if.overflow);
        end
      end
    end
  end

  // Watchdog: a run that hangs on a handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Type-name generators. Names are built two levels deep without
  // recursion; the matching pattern is built alongside, with some
  // arguments replaced by a star or left empty.
  // ---------------------------------------------------------------------
  function automatic string ident_text();
    string alpha;
    string s;
    int k;
    alpha = "ABCDxyz_9";
    s = "";
    repeat ($urandom_range(1, 4)) begin
      k = $urandom_range(0, alpha.len() - 1);
      s = {s, alpha.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string repeat_text(string s, int n);
    string t;
    t = "";
    repeat (n) t = {t, s};
    return t;
  endfunction

  // Append one argument to the name and its pattern form.
  function automatic void add_arg(input bit first, input string an, input string ap,
                                  inout string nm, inout string pt);
    if (!first) begin
      nm = {nm, ","};
      pt = {pt, ","};
    end
    case ($urandom_range(0, 5))
      0: ap = "*";
      1: ap = "";
      default: ;
    endcase
    nm = {nm, an};
    pt = {pt, ap};
  endfunction

  function automatic void gen_inner(output string nm, output string pt);
    string an;
    nm = ident_text();
    pt = nm;
    if ($urandom_range(0, 2) == 0) begin
      nm = {nm, "<"};
      pt = {pt, "<"};
      for (int i = 0; i < $urandom_range(1, 3); i++) begin
        an = ident_text();
        add_arg(i == 0, an, an, nm, pt);
      end
      nm = {nm, ">"};
      pt = {pt, ">"};
    end
  endfunction

  function automatic void gen_pair(output string nm, output string pt);
    string an, ap;
    int n;
    nm = ident_text();
    pt = nm;
    if ($urandom_range(0, 2) != 0) begin
      nm = {nm, "<"};
      pt = {pt, "<"};
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        gen_inner(an, ap);
        add_arg(i == 0, an, ap, nm, pt);
      end
      nm = {nm, ">"};
      pt = {pt, ">"};
    end
  endfunction

  // Break a name in one of a few ways: a changed character, a cut, an
  // extra closer or an unclosed opener.
  function automatic string mutate(string s);
    string sym;
    int k;
    sym = "<>,*Ab";
    if (s.len() < 2) return {s, "<Q"};
    k = $urandom_range(0, s.len() - 2);
    case ($urandom_range(0, 3))
      0: begin
        return {s.substr(0, k), sym.substr(k % 6, k % 6), s.substr(k + 2, s.len() - 1)};
      end
      1: return s.substr(0, k);
      2: return {s, ">"};
      default: return {s, "<Q"};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Literal patterns: exact match, spaces on either side, a wrong
  // character, a short name, an empty name and NUL bytes inside a name.
  task automatic test_plain_names();
    send_string(CmdFilter, "List < int >");
    send_string(CmdName, "List<int>");
    send_string(CmdName, " List <int > ");
    send_string(CmdName, "List<inx>");
    send_string(CmdName, "List<in");
    send_string(CmdName, "");
    send_item(CmdName, "L", 1'b0);
    send_item(CmdName, CharNul, 1'b0);
    send_string(CmdName, "ist<int>");
  endtask

  // Star and empty-slot arguments, nested arguments, an unclosed opener
  // inside a skip, and a star that meets the closing bracket.
  task automatic test_wildcards();
    send_string(CmdFilter, "Dict<*,*>");
    send_string(CmdName, "Dict<String,List<int>>");
    send_string(CmdName, "Dict<A,B<C");
    send_string(CmdName, "Dict<A,B<C>");
    send_string(CmdFilter, "Map<,>");
    send_string(CmdName, "Map<K<V>,W>");
    send_string(CmdName, "Map<K,W,X>");
    send_string(CmdFilter, "Tuple<*>");
    send_string(CmdName, "Tuple<>");
    send_string(CmdName, "Tuple<*>");
  endtask

  // Pattern handling: a name against an unfinished pattern, a pattern item
  // that cuts a name short, a fresh pattern after a closed one, the empty
  // pattern, high byte values and a pattern longer than the store.
  task automatic test_filter_edges();
    send_item(CmdFilter, "V", 1'b0);
    send_item(CmdFilter, "e", 1'b0);
    send_string(CmdName, "Ve");
    send_string(CmdName, "Vex");
    send_item(CmdName, "V", 1'b0);
    send_item(CmdFilter, "c", 1'b1);
    send_string(CmdName, "Vec");
    send_string(CmdFilter, "Q");
    send_string(CmdName, "Vec");
    send_string(CmdName, "Q");
    send_item(CmdFilter, CharNul, 1'b1);
    send_string(CmdName, "");
    send_string(CmdName, "Q");
    send_item(CmdFilter, 8'hFF, 1'b0);
    send_item(CmdFilter, 8'h55, 1'b0);
    send_item(CmdFilter, 8'hAA, 1'b1);
    send_item(CmdName, 8'hFF, 1'b0);
    send_item(CmdName, 8'h55, 1'b0);
    send_item(CmdName, 8'hAA, 1'b1);
    send_item(CmdName, 8'hFF, 1'b0);
    send_item(CmdName, 8'h55, 1'b0);
    send_item(CmdName, 8'hAB, 1'b1);
    send_string(CmdFilter, repeat_text("Ab", 35));
    send_string(CmdName, repeat_text("Ab", 32));
    send_string(CmdFilter, "Ok");
    send_string(CmdName, "Ok");
  endtask

  // Nesting inside a skipped argument beyond the bound, then within it.
  task automatic test_deep_nesting();
    send_string(CmdFilter, "A<*>");
    send_string(CmdName, {"A<X", repeat_text("<", NestMax + 2),
                          repeat_text(">", NestMax + 2), ">"});
    send_string(CmdName, {"A<X", repeat_text("<", NestMax),
                          repeat_text(">", NestMax), ">"});
  endtask

  // Mostly well-formed pattern and name pairs with random content, some of
  // them broken, plus noise, interrupted names, long patterns and deep
  // nesting. Runs until enough items and results have gone through.
  task automatic test_random_names();
    string nm, pt;
    int k;
    mess_on = 1'b1;
    while (n_items < ItemTarget || n_results < MinResults) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: begin
          gen_pair(nm, pt);
          send_string(CmdFilter, pt);
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) == 0) send_string(CmdName, mutate(nm));
            else send_string(CmdName, nm);
          end
        end
        6: begin
          // Raw noise over the whole byte range and both commands.
          repeat ($urandom_range(3, 10))
            send_item(cmd_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0);
        end
        7: begin
          // A name cut short by a pattern item, then a name on the new one.
          gen_pair(nm, pt);
          send_string(CmdFilter, pt);
          k = $urandom_range(0, nm.len() - 1);
          for (int i = 0; i <= k; i++) send_item(CmdName, nm.getc(i), 1'b0);
          send_item(CmdFilter, "Z", 1'b1);
          send_string(CmdName, $urandom_range(0, 1) ? "Z" : nm);
        end
        8: begin
          gen_pair(nm, pt);
          send_string(CmdName, nm);
        end
        9: begin
          // Pattern near or past the store size.
          pt = repeat_text(ident_text(), 20);
          pt = pt.substr(0, $urandom_range(PatDepth - 4, PatDepth + 6) % pt.len());
          send_string(CmdFilter, pt);
          send_string(CmdName, pt.substr(0, $urandom_range(0, pt.len() - 1)));
        end
        10: begin
          k = $urandom_range(NestMax - 5, NestMax + 5);
          send_string(CmdFilter, $urandom_range(0, 1) ? "N<*>" : "N<,>");
          send_string(CmdName, {"N<Z", repeat_text("<", k), repeat_text(">", k), ">"});
        end
        default: begin
          send_string(CmdFilter, "*");
          gen_pair(nm, pt);
          send_string(CmdName, nm);
        end
      endcase
    end
    mess_on = 1'b0;
  endtask

  // The receiver stops for a long stretch while names keep coming, so the
  // block fills and holds off its input; then the sender waits for every
  // result before going on.
  task automatic test_backpressure();
    string nm, pt;
    gen_pair(nm, pt);
    send_string(CmdFilter, pt);
    hold_req = 150;
    repeat (4) begin
      send_string(CmdName, "");
      send_string(CmdName, nm);
    end
    wait_drained();
  endtask

  // Final stretch with no gaps and no stalls on either side.
  task automatic test_steady_stream();
    string nm, pt;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (2) begin
      gen_pair(nm, pt);
      send_string(CmdFilter, pt);
      send_string(CmdName, nm);
      send_string(CmdName, mutate(nm));
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    mess_on    = 1'b0;
    hold_req   = 0;
    n_items    = 0;
    n_results  = 0;
    n_hits     = 0;
    n_ovf      = 0;
    n_mismatch = 0;
    cycles     = 0;
    pat_len     = 0;
    pat_closed  = 1'b0;
    pat_dropped = 1'b0;
    restart_name();
    rst_n         <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.cmd   <= CmdFilter;
    item_if.ch    <= CharNul;
    item_if.last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_names();
    test_wildcards();
    test_filter_edges();
    test_deep_nesting();
    test_random_names();
    test_backpressure();
    test_steady_stream();
    wait_drained();

    $display("Summary: %0d items sent (literal, star and empty-slot patterns, long patterns,",
             n_items);
    $display("deep nesting, noise, stalls); %0d results checked, %0d matched, %0d overflow.",
             n_results, n_hits, n_ovf);
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
